// ===== src/ivm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared sizes, controller states and the command/status bundles of the
// integer vector magnitude block.
// ----------------------------------------------------------------------------
package ivm_pkg;

  // Field and datapath sizes
  localparam int ElemWidth = 16;
  localparam int SqWidth   = 2 * ElemWidth;
  localparam int SumWidth  = 41;
  localparam int FracBits  = 8;
  localparam int MagWidth  = 29;
  localparam int SumPairs  = (SumWidth + 1) / 2;
  localparam int RootSteps = SumPairs + FracBits;
  localparam int StepWidth = $clog2(RootSteps);
  localparam int RemWidth  = MagWidth + 3;
  localparam int InTdataW  = ((ElemWidth + 7) / 8) * 8;
  localparam int OutTdataW = ((MagWidth + 7) / 8) * 8;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    StAccum = 5'b00001,
    StFlush = 5'b00010,
    StLoad  = 5'b00100,
    StRoot  = 5'b01000,
    StDone  = 5'b10000
  } ivm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic sq_en;      // register the square of the incoming element
    logic root_load;  // load the root unit from the finished sum
    logic root_step;  // one digit of the root
    logic out_load;   // move the root to the output register, clear the sum
  } ivm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register empty or drained this cycle
  } ivm_status_t;

endpackage : ivm_pkg
`default_nettype wire

// ===== src/ivm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivm_ctrl
// Sequencer: accepts elements, waits for the last square to land, steps the
// root unit digit by digit and hands the result to the output register.
// ----------------------------------------------------------------------------
module ivm_ctrl
  import ivm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_last_i,
  output logic             in_ready_o,
  output ivm_cmd_t         cmd_o,
  input  wire ivm_status_t status_i
);

  ivm_state_e            state_q, state_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic                  in_acc_w;

  assign in_ready_o = (state_q == StAccum);
  assign in_acc_w   = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      StAccum: begin
        cmd_o.sq_en = in_acc_w;
        if (in_acc_w && in_last_i) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        state_d = StLoad;
      end
      StLoad: begin
        cmd_o.root_load = 1'b1;
        step_d          = '0;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + StepWidth'(1);
        if (step_q == StepWidth'(RootSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StAccum;
        end
      end
      default: begin
        state_d = StAccum;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAccum;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule : ivm_ctrl
`default_nettype wire

// ===== src/ivm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivm_datapath
// Square register, saturating sum of squares, restoring square root one
// digit per cycle, and the output register.
// ----------------------------------------------------------------------------
module ivm_datapath
  import ivm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [ElemWidth-1:0]  elem_i,
  input  wire ivm_cmd_t              cmd_i,
  output ivm_status_t                status_o,
  output logic [MagWidth-1:0]        mag_o,
  output logic                       sat_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i
);

  logic [ElemWidth-1:0]    abs_w;
  logic [SqWidth-1:0]      sq_q;
  logic                    sq_vld_q;
  logic [SumWidth-1:0]     sum_q;
  logic                    ovf_q;
  logic [SumWidth:0]       sum_ext_w;
  logic [2*SumPairs-1:0]   shift_q;
  logic [1:0]              pair_w;
  logic [RemWidth-1:0]     rem_q, rem_sh_w, trial_w;
  logic [MagWidth-1:0]     root_q;
  logic                    ge_w;
  logic [MagWidth-1:0]     mag_q;
  logic                    sat_q;
  logic                    out_vld_q;

  // Magnitude of the element, two's complement
  assign abs_w = elem_i[ElemWidth-1] ? (~elem_i + ElemWidth'(1)) : elem_i;

  // Square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= cmd_i.sq_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= SqWidth'(abs_w) * SqWidth'(abs_w);
    end
  end

  // Accumulate, clamp at full scale
  assign sum_ext_w = {1'b0, sum_q} + (SumWidth + 1)'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (sq_vld_q) begin
      if (sum_ext_w[SumWidth]) begin
        sum_q <= '1;
        ovf_q <= 1'b1;
      end else begin
        sum_q <= sum_ext_w[SumWidth-1:0];
      end
    end
  end

  // Root digit: bring down a bit pair, try to subtract 4*root+1
  assign pair_w   = shift_q[2*SumPairs-1 -: 2];
  assign rem_sh_w = {rem_q[RemWidth-3:0], pair_w};
  assign trial_w  = RemWidth'({root_q, 2'b01});
  assign ge_w     = (rem_sh_w >= trial_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_load) begin
      shift_q <= (2 * SumPairs)'(sum_q);
      rem_q   <= '0;
      root_q  <= '0;
    end else if (cmd_i.root_step) begin
      shift_q <= {shift_q[2*SumPairs-3:0], 2'b00};
      rem_q   <= ge_w ? (rem_sh_w - trial_w) : rem_sh_w;
      root_q  <= {root_q[MagWidth-2:0], ge_w};
    end
  end

  // Output register
  assign status_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mag_q <= root_q;
      sat_q <= ovf_q;
    end
  end

  assign mag_o       = mag_q;
  assign sat_o       = sat_q;
  assign out_valid_o = out_vld_q;

endmodule : ivm_datapath
`default_nettype wire

// ===== src/int_vector_magnitude.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one element per cycle while a vector streams in.
// After the last element is taken the sequencer steps through its flush, load,
// root and done states; root runs the one-digit-per-cycle square root iteration.
// Input is held off from the last element until the root reaches the output
// register (and that register is free). Reset is asynchronous, active low,
// and clears the sum, the overflow flag, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// int_vector_magnitude
// Euclidean magnitude of a stream of signed elements, as unsigned fixed
// point with 8 fraction bits, truncated, with a saturation flag.
// ----------------------------------------------------------------------------
module int_vector_magnitude
  import ivm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [InTdataW-1:0]   s_axis_tdata_i,  // [15:0] element (signed)
  input  wire logic                  s_axis_tlast_i,  // last_element
  // Result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OutTdataW-1:0]       m_axis_tdata_o,  // [28:0] magnitude, zero above
  output logic                       m_axis_tuser_o   // [0] saturated
);

  ivm_cmd_t             cmd;
  ivm_status_t          status;
  logic [MagWidth-1:0]  mag;

  ivm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ivm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .elem_i      (s_axis_tdata_i[ElemWidth-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .mag_o       (mag),
    .sat_o       (m_axis_tuser_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  // Pad the magnitude to whole bytes
  assign m_axis_tdata_o = OutTdataW'(mag);

endmodule : int_vector_magnitude
`default_nettype wire
